[sv/tbts_pkg.sv]
// Package for the timer bank task scheduler: shared constants, operation and
// status codes, controller states and the controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package tbts_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int DELAY_W  = 16;
  localparam int ID_W     = 8;
  localparam int COUNT_W  = 8;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam int S_TDATA_W = 40;  // start_delay, repeat_period, target_id
  localparam int S_TUSER_W = 2;   // func
  localparam int M_TDATA_W = 8;   // out_id
  localparam int M_TUSER_W = 3;   // status, dispatched

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_DELETE   = 2'd2,
    FUNC_DISPATCH = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // One slot record as kept in the slot memory.
  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
    logic [COUNT_W-1:0] count;
    logic [ID_W-1:0]    ident;
  } rec_t;

  typedef struct packed {
    logic load;   // latch a new item and restart the slot walk
    logic scan;   // walk the slots and act on them
    logic emit;   // load the result into the output register
  } cmd_t;

  typedef struct packed {
    logic done;      // walk finished, either by a hit or at the last slot
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

[sv/tbts_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tbts_ctrl.sv]
// Controller of the timer bank task scheduler: sequences accept, slot walk
// and result hand-off. Depends on tbts_pkg.
`timescale 1ns / 1ps

module tbts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output tbts_pkg::cmd_t cmd_o,
  input  tbts_pkg::stat_t stat_i
);
  import tbts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/tbts_datapath.sv]
// Datapath of the timer bank task scheduler: slot memory, used bits, counters,
// the slot walk pipeline and the output register. Depends on tbts_pkg, tbts_ram.
`timescale 1ns / 1ps

module tbts_datapath #(
  parameter int SLOT_COUNT = tbts_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tbts_pkg::cmd_t                  cmd_i,
  output tbts_pkg::stat_t                 stat_o,
  input  logic [tbts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic [tbts_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tbts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic [tbts_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import tbts_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UC_W  = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [UC_W-1:0]  UC_ONE   = UC_W'(1);

  // Latched item.
  func_e              func_q;
  logic [DELAY_W-1:0] delay_q;
  logic [DELAY_W-1:0] period_q;
  logic [ID_W-1:0]    target_q;

  logic [SLOT_COUNT-1:0] used_q;
  logic [UC_W-1:0]       used_cnt_q;
  logic [ID_W-1:0]       ident_q;

  // Walk: read issue side and the stage that sees the read data.
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_more_q;
  logic             p_valid_q;
  logic [IDX_W-1:0] p_idx_q;

  logic            hit_q;
  logic [ID_W-1:0] res_id_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [ID_W-1:0]    out_id_q;
  logic               out_disp_q;

  logic [$bits(rec_t)-1:0] ram_rdata;
  rec_t rd_rec;
  rec_t wr_rec;
  rec_t tick_rec;
  logic ram_we;
  logic slot_used;
  logic act;
  logic hit_now;
  logic clear_used;
  logic set_used;
  logic last_slot;
  logic [ID_W-1:0] ident_next;
  status_e res_status;
  logic [ID_W-1:0] res_id;
  logic res_disp;

  assign rd_rec     = rec_t'(ram_rdata);
  assign slot_used  = used_q[p_idx_q];
  assign act        = cmd_i.scan && p_valid_q;
  assign last_slot  = p_valid_q && (p_idx_q == LAST_IDX);
  assign ident_next = ident_q + ID_W'(1);

  always_comb begin
    tick_rec = rd_rec;
    if (rd_rec.delay != '0) begin
      tick_rec.delay = rd_rec.delay - DELAY_W'(1);
    end
    if (tick_rec.delay == '0) begin
      if (rd_rec.count != COUNT_MAX) begin
        tick_rec.count = rd_rec.count + COUNT_W'(1);
      end
      if (rd_rec.period != '0) begin
        tick_rec.delay = rd_rec.period;
      end
    end
  end

  always_comb begin
    ram_we     = 1'b0;
    wr_rec     = rd_rec;
    hit_now    = 1'b0;
    clear_used = 1'b0;
    set_used   = 1'b0;
    if (act) begin
      unique case (func_q)
        FUNC_TICK: begin
          if (slot_used) begin
            ram_we = 1'b1;
            wr_rec = tick_rec;
          end
        end
        FUNC_ADD: begin
          if (!slot_used) begin
            hit_now      = 1'b1;
            set_used     = 1'b1;
            ram_we       = 1'b1;
            wr_rec.delay  = delay_q;
            wr_rec.period = period_q;
            wr_rec.count  = '0;
            wr_rec.ident  = ident_next;
          end
        end
        FUNC_DELETE: begin
          if (slot_used && (rd_rec.ident == target_q)) begin
            hit_now    = 1'b1;
            clear_used = 1'b1;
          end
        end
        FUNC_DISPATCH: begin
          if (slot_used && (rd_rec.count != '0)) begin
            hit_now      = 1'b1;
            ram_we       = 1'b1;
            wr_rec.count = rd_rec.count - COUNT_W'(1);
            clear_used   = (rd_rec.period == '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.done     = hit_now || (cmd_i.scan && last_slot);
  assign stat_o.out_free = !out_valid_q || m_axis_tready;

  tbts_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(SLOT_COUNT),
    .ADDR_W(IDX_W)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(p_idx_q),
    .wdata_i(wr_rec),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  // Item latch; payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_e'(s_axis_tuser[FUNC_W-1:0]);
      delay_q  <= s_axis_tdata[DELAY_W-1:0];
      period_q <= s_axis_tdata[2*DELAY_W-1:DELAY_W];
      target_q <= s_axis_tdata[2*DELAY_W+ID_W-1:2*DELAY_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      used_cnt_q <= '0;
      ident_q    <= '0;
      rd_idx_q   <= '0;
      rd_more_q  <= 1'b0;
      p_valid_q  <= 1'b0;
      p_idx_q    <= '0;
      hit_q      <= 1'b0;
      res_id_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q  <= '0;
        rd_more_q <= 1'b1;
        p_valid_q <= 1'b0;
        hit_q     <= 1'b0;
        res_id_q  <= '0;
      end else if (cmd_i.scan) begin
        p_valid_q <= rd_more_q;
        p_idx_q   <= rd_idx_q;
        if (rd_more_q) begin
          if (rd_idx_q == LAST_IDX) begin
            rd_more_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
          end
        end
      end
      if (hit_now) begin
        hit_q <= 1'b1;
        res_id_q <= (func_q == FUNC_ADD) ? ident_next : rd_rec.ident;
      end
      if (set_used) begin
        used_q[p_idx_q] <= 1'b1;
        used_cnt_q      <= used_cnt_q + UC_ONE;
        ident_q         <= ident_next;
      end
      if (clear_used) begin
        used_q[p_idx_q] <= 1'b0;
        used_cnt_q      <= used_cnt_q - UC_ONE;
      end
    end
  end

  always_comb begin
    res_status = STATUS_OK;
    res_id     = '0;
    res_disp   = 1'b0;
    unique case (func_q)
      FUNC_TICK: begin
      end
      FUNC_ADD: begin
        if (hit_q) begin
          res_id = res_id_q;
        end else begin
          res_status = STATUS_FULL;
        end
      end
      FUNC_DELETE: begin
        // A miss on a nonempty bank is not an error.
        if (!hit_q && (used_cnt_q == '0)) begin
          res_status = STATUS_EMPTY;
        end
      end
      FUNC_DISPATCH: begin
        if (hit_q) begin
          res_id   = res_id_q;
          res_disp = 1'b1;
        end else begin
          res_status = STATUS_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_disp_q   <= res_disp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = {out_disp_q, out_status_q};

endmodule

[sv/timer_bank_task_scheduler_top.sv]
// Top level of the timer bank task scheduler: joins controller and datapath.
// Depends on tbts_pkg, tbts_ctrl, tbts_datapath (and tbts_ram below it).
`timescale 1ns / 1ps

// A bank of SLOT_COUNT task timer slots driven by one operation per input item
// (tick, add, delete, dispatch) with one result item per input item. Every
// operation walks the slot memory one slot per cycle through its registered
// read port; an item is accepted, walks the slots, and has its result
// registered once the output register is free. Add, delete and dispatch
// stop the walk at the first slot they act on; tick always visits every
// slot. One item is worked on at a time; the next is accepted once the
// result has been loaded into the output register, even while that result
// waits to be taken. No clearing pass is needed after reset: a slot's
// contents are used only while it is marked used.
module timer_bank_task_scheduler_top #(
  parameter int SLOT_COUNT = tbts_pkg::SLOT_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_delay[15:0], repeat_period[31:16], target_id[39:32]
  input  logic [tbts_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  logic [tbts_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_id[7:0]
  output logic [tbts_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0], dispatched[2]
  output logic [tbts_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import tbts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tbts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  tbts_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

[sv/tbts_checker.sv]
// Port-level checker for the timer bank task scheduler, bound to the top level.
// Depends on tbts_pkg and timer_bank_task_scheduler_top.
`timescale 1ns / 1ps

module tbts_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tbts_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [tbts_pkg::M_TUSER_W-1:0] m_axis_tuser
);
  import tbts_pkg::*;

  logic    disp;
  status_e status;

  assign status = status_e'(m_axis_tuser[STATUS_W-1:0]);
  assign disp   = m_axis_tuser[STATUS_W];

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The controller leaves the idle state on accepting an item, so no item directly follows another.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted during a walk");

  // Dispatch is reported only together with an ok status.
  a_disp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && disp |-> status == STATUS_OK)
    else $error("dispatched flag with error status");

  // Any error result carries a zero identifier.
  a_err_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != STATUS_OK) |-> (m_axis_tdata == '0) && !disp)
    else $error("error result with nonzero identifier");

endmodule

bind timer_bank_task_scheduler_top tbts_checker u_tbts_checker (.*);

[dv/tb_timer_bank_task_scheduler_top.sv]
// Testbench for the timer bank task scheduler: drives tick, add, delete and dispatch items
// and checks every result against a cycle-free model of the slot bank kept in a scoreboard.
// Depends on tbts_pkg and timer_bank_task_scheduler_top.
`timescale 1ns / 1ps

module tb_timer_bank_task_scheduler_top;
  import tbts_pkg::*;

  localparam int NSLOT      = SLOT_COUNT_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYC  = 2 * NSLOT + 8;

  typedef struct {
    status_e          status;
    logic [ID_W-1:0]  id;
    logic             disp;
  } sched_result_t;

  // Keeps its own copy of the slot bank and the results it expects.
  class sched_scoreboard;
    bit                  used [NSLOT];
    logic [DELAY_W-1:0]  delay [NSLOT];
    logic [DELAY_W-1:0]  period [NSLOT];
    logic [COUNT_W-1:0]  count [NSLOT];
    logic [ID_W-1:0]     ident [NSLOT];
    logic [ID_W-1:0]     id_ctr;
    int                  n_used;
    sched_result_t       expected_q [$];
    int                  errors;

    function new();
      foreach (used[s]) used[s] = 1'b0;
      id_ctr = '0;
      n_used = 0;
      errors = 0;
    endfunction

    function void note_item(func_e f, logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] p,
                            logic [ID_W-1:0] t);
      sched_result_t r;
      int hit;
      r.status = STATUS_OK;
      r.id = '0;
      r.disp = 1'b0;
      hit = -1;
      case (f)
        FUNC_TICK: begin
          for (int s = 0; s < NSLOT; s++) begin
            if (used[s]) begin
              if (delay[s] != 0) delay[s] = delay[s] - 1'b1;
              if (delay[s] == 0) begin
                if (count[s] != COUNT_MAX) count[s] = count[s] + 1'b1;
                if (period[s] != 0) delay[s] = period[s];
              end
            end
          end
        end
        FUNC_ADD: begin
          for (int s = 0; s < NSLOT; s++) if (!used[s] && hit < 0) hit = s;
          if (hit < 0) begin
            r.status = STATUS_FULL;
          end else begin
            id_ctr = id_ctr + 1'b1;
            used[hit] = 1'b1;
            delay[hit] = d;
            period[hit] = p;
            count[hit] = '0;
            ident[hit] = id_ctr;
            n_used++;
            r.id = id_ctr;
          end
        end
        FUNC_DELETE: begin
          if (n_used == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            // With duplicate identifiers only the lowest matching slot goes.
            for (int s = 0; s < NSLOT; s++) if (used[s] && ident[s] == t && hit < 0) hit = s;
            if (hit >= 0) begin
              used[hit] = 1'b0;
              n_used--;
            end
          end
        end
        default: begin
          for (int s = 0; s < NSLOT; s++) if (used[s] && count[s] != 0 && hit < 0) hit = s;
          if (hit < 0) begin
            r.status = STATUS_NONE;
          end else begin
            r.id = ident[hit];
            r.disp = 1'b1;
            count[hit] = count[hit] - 1'b1;
            if (period[hit] == 0) begin
              used[hit] = 1'b0;
              n_used--;
            end
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id, logic disp);
      sched_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d id %0d dispatched %0d",
                 $time, st, id, disp);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.status !== st) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (e.id !== id) begin
        $display("%0t: out_id mismatch: expected %0d actual %0d", $time, e.id, id);
        errors++;
      end
      if (e.disp !== disp) begin
        $display("%0t: dispatched mismatch: expected %0d actual %0d", $time, e.disp, disp);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [ID_W-1:0] live_id();
      logic [ID_W-1:0] ids [$];
      foreach (used[s]) if (used[s]) ids.push_back(ident[s]);
      if (ids.size() == 0) return ID_W'($urandom);
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;

  bit calm = 1'b0;
  sched_scoreboard sb = new();

  timer_bank_task_scheduler_top #(.SLOT_COUNT(NSLOT)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: ready most of the time, with stall bursts until the calm phase.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser[1:0], m_axis_tdata[ID_W-1:0], m_axis_tuser[2]);
  end

  initial begin : watchdog
    int idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cyc = 0;
      else
        idle_cyc++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly small values so that tasks come due, now and then a full-width one.
  function automatic logic [DELAY_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return DELAY_W'($urandom);
    return DELAY_W'($urandom_range(0, 4));
  endfunction

  function automatic logic [DELAY_W-1:0] rand_word();
    return DELAY_W'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  task automatic send_item(func_e f, logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] p,
                           logic [ID_W-1:0] t);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, p, d};
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(f, d, p, t);
  endtask

  task automatic random_op();
    int r;
    logic [ID_W-1:0] t;
    r = $urandom_range(0, 99);
    t = rand_id();
    if (r < 40) begin
      send_item(FUNC_ADD, pick_value(), pick_value(), t);
    end else if (r < 65) begin
      if ($urandom_range(0, 3) != 0) t = sb.live_id();
      send_item(FUNC_DELETE, rand_word(), rand_word(), t);
    end else if (r < 85) begin
      send_item(FUNC_TICK, rand_word(), rand_word(), t);
    end else begin
      send_item(FUNC_DISPATCH, rand_word(), rand_word(), t);
    end
  endtask

  // A lone one-shot task that is due on every tick, ticked 256 times: its ready
  // count must stop at the top instead of wrapping, so it still wins the dispatch
  // against the periodic task in the slot above it.
  task automatic saturate_count();
    while (sb.n_used != 0) send_item(FUNC_DELETE, rand_word(), rand_word(), sb.live_id());
    send_item(FUNC_ADD, 16'd0, 16'd0, rand_id());
    send_item(FUNC_ADD, 16'd2, 16'd3, rand_id());
    repeat (256) send_item(FUNC_TICK, rand_word(), rand_word(), rand_id());
    repeat (4) send_item(FUNC_DISPATCH, rand_word(), rand_word(), rand_id());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty bank: nothing ready, delete rejected.
    send_item(FUNC_DISPATCH, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(FUNC_DELETE, 16'h0000, 16'h0000, 8'hFF);
    // One-shot due at once: ready after one tick, freed on dispatch.
    send_item(FUNC_ADD, 16'h0000, 16'h0000, 8'h00);
    send_item(FUNC_TICK, 16'h0000, 16'h0000, 8'h00);
    send_item(FUNC_DISPATCH, 16'h0000, 16'h0000, 8'h00);
    // Extreme delay and period next to a periodic task due every tick.
    send_item(FUNC_ADD, 16'hFFFF, 16'hFFFF, 8'h00);
    send_item(FUNC_ADD, 16'h0001, 16'h0001, 8'hFF);
    send_item(FUNC_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(FUNC_DISPATCH, 16'hFFFF, 16'hFFFF, 8'hFF);
    // Fill the bank and add once more while it is full.
    repeat (NSLOT - 1) send_item(FUNC_ADD, pick_value(), pick_value(), rand_id());
    // Delete of an identifier that no slot holds.
    send_item(FUNC_DELETE, 16'h0000, 16'h0000, 8'h00);

    repeat (80) random_op();
    saturate_count();
    repeat (50) random_op();
    calm = 1'b1;
    repeat (70) random_op();
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[timer_bank_task_scheduler_top.f]
sv/tbts_pkg.sv
sv/tbts_ram.sv
sv/tbts_ctrl.sv
sv/tbts_datapath.sv
sv/timer_bank_task_scheduler_top.sv
sv/tbts_checker.sv
dv/tb_timer_bank_task_scheduler_top.sv
